// ----- rtl/two_layer_chip_spreading_transmitter_top_macros.svh -----
// Assertion macros shared by the two-layer chip spreading transmitter.
`ifndef TWO_LAYER_CHIP_SPREADING_TRANSMITTER_TOP_MACROS_SVH
`define TWO_LAYER_CHIP_SPREADING_TRANSMITTER_TOP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define TLCST_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define TLCST_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tlcst_pkg.sv -----
// Shared constants, types and chip-spreading functions of the transmitter.
`timescale 1ns / 1ps
package tlcst_pkg;

	localparam int QUEUE_DEPTH = 1024;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = IDX_W + 1;
	localparam int WORD_W = 32;
	localparam int BIT_W = $clog2(WORD_W);
	localparam int CHIPS = WORD_W / 2;

	localparam logic [WORD_W-1:0] PREAMBLE_WORD = 32'h5555_5555;
	localparam logic [WORD_W-1:0] SYNC_WORD = 32'hD555_5555;
	localparam logic [7:0] LEVEL_HIGH_BYTE = 8'hFF;
	localparam logic [7:0] LEVEL_LOW_BYTE = 8'h00;

	localparam int BYTE_WORDS = 2;
	localparam int PREAMBLE_WORDS = 4;
	localparam int START_WORDS = 12;
	localparam int SEQ_W = 4;

	localparam int CMD_FIFO_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_FIFO_DEPTH);

	// Operation codes carried in tuser.
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_BYTE = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_BYTE,
		CMD_START,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [7:0] data;
	} cmd_t;

	// Result fields, last field in the lowest bit.
	typedef struct packed {
		logic dropped;
		logic busy_res;
		logic led_layer2;
		logic led_layer1;
	} res_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic [CNT_W-1:0] used;
	} back_status_t;

	function automatic logic [CHIPS-1:0] chip_pattern(input logic [1:0] sel);
		logic [CHIPS-1:0] p;
		case (sel)
			2'd0: p = 16'h3CC3;
			2'd1: p = 16'h9696;
			2'd2: p = 16'h6969;
			2'd3: p = 16'hC33C;
			default: p = '0;
		endcase
		return p;
	endfunction

	// Every chip fills two neighboring bits of the word.
	function automatic logic [WORD_W-1:0] double_chips(input logic [CHIPS-1:0] c);
		logic [WORD_W-1:0] r;
		for (int i = 0; i < CHIPS; i++) begin
			r[2*i] = c[i];
			r[2*i+1] = c[i];
		end
		return r;
	endfunction

	// Layer 2 word in the upper half, layer 1 word in the lower half.
	function automatic logic [2*WORD_W-1:0] nibble_words(input logic [3:0] nib);
		logic [WORD_W-1:0] w1;
		logic [WORD_W-1:0] w2;
		w1 = double_chips(chip_pattern(nib[1:0]));
		w2 = double_chips(chip_pattern(~nib[3:2]));
		return {w2, w1};
	endfunction

	// Word pair number seq of a queued byte or of the start frame.
	function automatic logic [2*WORD_W-1:0] frame_words(input logic is_start,
			input logic [SEQ_W-1:0] seq, input logic [7:0] data);
		logic [7:0] b;
		logic [2*WORD_W-1:0] w;
		if (is_start && seq < SEQ_W'(PREAMBLE_WORDS - 1)) begin
			w = {PREAMBLE_WORD, PREAMBLE_WORD};
		end else if (is_start && seq == SEQ_W'(PREAMBLE_WORDS - 1)) begin
			w = {SYNC_WORD, SYNC_WORD};
		end else begin
			if (!is_start) begin
				b = data;
			end else if (seq >= SEQ_W'(START_WORDS - BYTE_WORDS)) begin
				b = LEVEL_LOW_BYTE;
			end else begin
				b = LEVEL_HIGH_BYTE;
			end
			w = nibble_words(seq[0] ? b[7:4] : b[3:0]);
		end
		return w;
	endfunction

endpackage

// ----- rtl/two_layer_chip_spreading_transmitter_top.sv -----
// Top level of the two-layer chip spreading transmitter.
`timescale 1ns / 1ps
// The transmitter takes one command per input transfer: a tick that shifts
// one bit of the current word to both emitters, a byte to be spread into two
// 32-bit chip words per layer, or a start that queues the preamble, the sync
// word and the level-check bytes and then raises busy. Every input transfer
// yields exactly one output transfer carrying both emitter levels, the busy
// flag and a flag that tells whether a byte or start was refused for lack of
// queue space. The front end classifies each transfer and pushes it into a
// four-entry command queue, so it takes one transfer per cycle while that
// queue has room, even while a result waits on the output. The back end works
// through the commands in order: a tick that shifts a bit reads the word
// memories and waits in a tick state for their registered read data; a byte
// writes its two words one after the other through the single write port of
// each layer memory; a start writes its twelve words the same way; every other
// command is answered from the idle state. The word memories hold 1023 words
// in use and need no clearing after reset, since only written words are read.
`include "two_layer_chip_spreading_transmitter_top_macros.svh"
module two_layer_chip_spreading_transmitter_top
	import tlcst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] byte_value
	input  logic [1:0] s_axis_tuser,  // [1:0] operation
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata   // [0] led_layer1, [1] led_layer2,
	                                  // [2] busy_res, [3] dropped, [7:4] zero
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;
	res_t out_res;
	back_status_t status;

	// Classification of the incoming transfer.
	tlcst_front u_front (
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_cmd     (push_cmd)
	);

	// The queue lets the front end keep accepting while the back end writes.
	tlcst_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd)
	);

	// Word memories, frame writer and bit shifter.
	tlcst_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(pop_valid),
		.cmd_ready(pop_ready),
		.cmd      (pop_cmd),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (out_res),
		.status   (status)
	);

	assign m_axis_tdata = {4'b0000, out_res};

	// The emitters are only lit while a frame is in flight.
	`TLCST_ASSERT_IMPLY(a_leds_off_when_idle, m_axis_tvalid && !m_axis_tdata[2], m_axis_tdata[1:0] == 2'b00, "emitter lit while not busy")
	// A word is never read in the cycle a word is written.
	`TLCST_ASSERT_ALWAYS(a_no_read_write_overlap, !(status.rd_en && status.wr_en), "word read and write overlap")
	// The ring never holds more than its depth less one word.
	`TLCST_ASSERT_ALWAYS(a_queue_fill_bound, status.used <= CNT_W'(QUEUE_DEPTH - 1), "word queue overfilled")

endmodule

// ----- rtl/tlcst_ram.sv -----
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module tlcst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/tlcst_front.sv -----
// Front end: accepts input transfers and classifies them into commands.
`timescale 1ns / 1ps
module tlcst_front
	import tlcst_pkg::*;
(
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,
	input  logic [1:0] s_axis_tuser,
	output logic       push_valid,
	input  logic       push_ready,
	output cmd_t       push_cmd
);

	always_comb begin
		push_cmd.data = s_axis_tdata;
		case (s_axis_tuser)
			OP_TICK: push_cmd.kind = CMD_TICK;
			OP_BYTE: push_cmd.kind = CMD_BYTE;
			OP_START: push_cmd.kind = CMD_START;
			default: push_cmd.kind = CMD_NOP;
		endcase
	end

	assign push_valid = s_axis_tvalid;
	assign s_axis_tready = push_ready;

endmodule

// ----- rtl/tlcst_cmd_fifo.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module tlcst_cmd_fifo
	import tlcst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t ent_q [CMD_FIFO_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_PTR_W:0] count_q;
	logic push;
	logic pop;

	assign push_ready = count_q != (CMD_PTR_W+1)'(CMD_FIFO_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_cmd = ent_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/tlcst_back.sv -----
// Back end: word queue, frame writer, bit shifter and result register.
`timescale 1ns / 1ps
module tlcst_back
	import tlcst_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	output logic         cmd_ready,
	input  cmd_t         cmd,
	output logic         out_valid,
	input  logic         out_ready,
	output res_t         out_res,
	output back_status_t status
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_WRITE
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] wr_idx_q;
	logic [BIT_W-1:0] bit_pos_q;
	logic sending_q;
	logic led1_q;
	logic led2_q;
	logic [SEQ_W-1:0] seq_q;
	logic is_start_q;
	logic [7:0] data_q;
	logic out_valid_q;
	res_t out_res_q;

	logic [CNT_W-1:0] used;
	logic [CNT_W-1:0] free;
	logic empty;
	logic out_free;
	logic take;
	logic byte_ok;
	logic start_ok;
	logic rd_en;
	logic wr_en;
	logic wr_is_start;
	logic [SEQ_W-1:0] wr_seq;
	logic [7:0] wr_byte;
	logic [2*WORD_W-1:0] wr_words;
	logic [WORD_W-1:0] rd_word1;
	logic [WORD_W-1:0] rd_word2;
	logic [SEQ_W-1:0] last_seq;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	always_comb begin
		if (wr_idx_q >= rd_idx_q) begin
			used = {1'b0, wr_idx_q} - {1'b0, rd_idx_q};
		end else begin
			used = {1'b0, wr_idx_q} + CNT_W'(QUEUE_DEPTH) - {1'b0, rd_idx_q};
		end
	end

	assign free = CNT_W'(QUEUE_DEPTH - 1) - used;
	assign empty = rd_idx_q == wr_idx_q;
	assign out_free = !out_valid_q || out_ready;
	assign cmd_ready = (state_q == ST_IDLE) && out_free;
	assign take = cmd_valid && cmd_ready;
	assign byte_ok = free >= CNT_W'(BYTE_WORDS);
	assign start_ok = !sending_q && free >= CNT_W'(START_WORDS);

	assign rd_en = take && cmd.kind == CMD_TICK && sending_q && !empty;
	assign wr_en = (state_q == ST_WRITE)
		|| (take && cmd.kind == CMD_BYTE && byte_ok)
		|| (take && cmd.kind == CMD_START && start_ok);

	assign wr_is_start = (state_q == ST_WRITE) ? is_start_q : (cmd.kind == CMD_START);
	assign wr_seq = (state_q == ST_WRITE) ? seq_q : '0;
	assign wr_byte = (state_q == ST_WRITE) ? data_q : cmd.data;
	assign wr_words = frame_words(wr_is_start, wr_seq, wr_byte);
	assign last_seq = is_start_q ? SEQ_W'(START_WORDS - 1) : SEQ_W'(BYTE_WORDS - 1);

	tlcst_ram #(
		.WIDTH(WORD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_layer1_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_idx_q),
		.wr_data(wr_words[WORD_W-1:0]),
		.rd_en  (rd_en),
		.rd_addr(rd_idx_q),
		.rd_data(rd_word1)
	);

	tlcst_ram #(
		.WIDTH(WORD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_layer2_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_idx_q),
		.wr_data(wr_words[2*WORD_W-1:WORD_W]),
		.rd_en  (rd_en),
		.rd_addr(rd_idx_q),
		.rd_data(rd_word2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			bit_pos_q <= '0;
			sending_q <= 1'b0;
			led1_q <= 1'b0;
			led2_q <= 1'b0;
			seq_q <= '0;
			is_start_q <= 1'b0;
			data_q <= '0;
			out_valid_q <= 1'b0;
			out_res_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				wr_idx_q <= next_idx(wr_idx_q);
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (cmd.kind)
							CMD_TICK: begin
								if (sending_q && !empty) begin
									state_q <= ST_TICK;
								end else if (sending_q) begin
									led1_q <= 1'b0;
									led2_q <= 1'b0;
									sending_q <= 1'b0;
									out_res_q <= '0;
									out_valid_q <= 1'b1;
								end else begin
									out_res_q <= '{1'b0, sending_q, led2_q, led1_q};
									out_valid_q <= 1'b1;
								end
							end
							CMD_BYTE: begin
								if (byte_ok) begin
									state_q <= ST_WRITE;
									seq_q <= SEQ_W'(1);
									is_start_q <= 1'b0;
									data_q <= cmd.data;
								end
								out_res_q <= '{!byte_ok, sending_q, led2_q, led1_q};
								out_valid_q <= 1'b1;
							end
							CMD_START: begin
								if (sending_q) begin
									out_res_q <= '{1'b0, 1'b1, led2_q, led1_q};
								end else if (start_ok) begin
									sending_q <= 1'b1;
									state_q <= ST_WRITE;
									seq_q <= SEQ_W'(1);
									is_start_q <= 1'b1;
									out_res_q <= '{1'b0, 1'b1, led2_q, led1_q};
								end else begin
									out_res_q <= '{1'b1, 1'b0, led2_q, led1_q};
								end
								out_valid_q <= 1'b1;
							end
							default: begin
								out_res_q <= '{1'b0, sending_q, led2_q, led1_q};
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_TICK: begin
					led1_q <= rd_word1[bit_pos_q];
					led2_q <= rd_word2[bit_pos_q];
					bit_pos_q <= bit_pos_q + 1'b1;
					if (bit_pos_q == BIT_W'(WORD_W - 1)) begin
						rd_idx_q <= next_idx(rd_idx_q);
					end
					out_res_q <= '{1'b0, 1'b1, rd_word2[bit_pos_q], rd_word1[bit_pos_q]};
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_WRITE: begin
					if (seq_q == last_seq) begin
						state_q <= ST_IDLE;
					end else begin
						seq_q <= seq_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_res = out_res_q;
	assign status.rd_en = rd_en;
	assign status.wr_en = wr_en;
	assign status.used = used;

endmodule
